// ----- src/tghl_pkg.sv -----
// Shared types and constants for the terrain grid height lookup.
package tghl_pkg;

  localparam int LAT_BITS       = 28;
  localparam int LON_BITS       = 29;
  localparam int CPD_BITS       = 13;
  localparam int ROW_BITS       = 8;
  localparam int COL_BITS       = 8;
  localparam int POST_BITS      = 16;
  localparam int HEIGHT_BITS    = 24;
  localparam int FRAC_BITS      = 20;
  localparam int WEIGHT_BITS    = 16;
  localparam int N_BANKS        = 4;
  localparam int BANK_SEL_BITS  = 2;
  localparam int BANK_ADDR_BITS = (ROW_BITS - 1) + (COL_BITS - 1);
  localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 29;
  localparam int RESULT_DEPTH    = 16;
  localparam int RESULT_PTR_BITS = 4;

  localparam logic [ROW_BITS-1:0] LAST_ROW = '1;
  localparam logic [COL_BITS-1:0] LAST_COL = '1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_NORTH_EDGE       = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WEST_EDGE        = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CELLS_PER_DEGREE = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_NEAREST  = 2'd1,
    CMD_BILINEAR = 2'd2
  } cmd_e;

  typedef struct packed {
    logic                 en;
    logic [ROW_BITS-1:0]  row;
    logic [COL_BITS-1:0]  col;
    logic [POST_BITS-1:0] height;
  } post_wr_t;

  typedef struct packed {
    logic                   valid;
    logic                   ok;
    logic [WEIGHT_BITS-1:0] frac_row;
    logic [WEIGHT_BITS-1:0] frac_col;
    logic                   clamp_row;
    logic                   clamp_col;
    logic                   row_odd;
    logic                   col_odd;
  } lookup_t;

endpackage

// ----- src/terrain_grid_height_lookup.sv -----
// Top level of the terrain grid height lookup.
// Takes one item per clock while s_axis_tready is high: a post write or a nearest or
// bilinear height query. Posts sit in four row/column parity banks, so the four
// neighbors of a query come out of one read and the blend runs as a pipeline; results
// pass the scale, bank and blend registers and the result queue. Up to 16 query results
// may be in flight or waiting in the output queue; s_axis_tready drops while all 16
// slots are held. Writes produce no result and take effect before any later query reads
// the post. Post storage is not cleared at reset: read only posts that were written.
module terrain_grid_height_lookup
  import tghl_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // latitude, longitude, post_row, post_column, post_height, zero pad
  input  logic [95:0]               s_axis_tdata,
  // command
  input  logic [1:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // height
  output logic [HEIGHT_BITS-1:0]    m_axis_tdata,
  // in_range
  output logic [0:0]                m_axis_tuser,
  input  logic                      cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int LAT_LSB = 0;
  localparam int LON_LSB = LAT_LSB + LAT_BITS;
  localparam int ROW_LSB = LON_LSB + LON_BITS;
  localparam int COL_LSB = ROW_LSB + ROW_BITS;
  localparam int HGT_LSB = COL_LSB + COL_BITS;

  logic signed [LAT_BITS-1:0]   north_q;
  logic signed [LON_BITS-1:0]   west_q;
  logic [CPD_BITS-1:0]          cpd_q;
  logic [RESULT_PTR_BITS:0]     outstanding_q, outstanding_d;
  logic                         in_acc, query_acc, pop;
  cmd_e                         cmd;

  post_wr_t                     post_wr;
  logic                         rd_en;
  logic [BANK_ADDR_BITS-1:0]    rd_addr [N_BANKS];
  logic [POST_BITS-1:0]         rd_data [N_BANKS];
  lookup_t                      look;
  logic                         res_valid, res_in_range;
  logic signed [HEIGHT_BITS-1:0] res_height;
  logic [HEIGHT_BITS:0]         fifo_data;

  assign cmd       = cmd_e'(s_axis_tuser);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign query_acc = in_acc && (cmd == CMD_NEAREST || cmd == CMD_BILINEAR);
  assign pop       = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (outstanding_q != (RESULT_PTR_BITS + 1)'(RESULT_DEPTH));
  assign outstanding_d = outstanding_q + (RESULT_PTR_BITS + 1)'(query_acc)
                         - (RESULT_PTR_BITS + 1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      north_q       <= LAT_BITS'(94371840);
      west_q        <= LON_BITS'(-188743680);
      cpd_q         <= CPD_BITS'(120);
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_NORTH_EDGE:       north_q <= cfg_data_i[LAT_BITS-1:0];
          REG_WEST_EDGE:        west_q  <= cfg_data_i[LON_BITS-1:0];
          REG_CELLS_PER_DEGREE: cpd_q   <= cfg_data_i[CPD_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  tghl_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_acc),
    .cmd_i        (cmd),
    .lat_i        (s_axis_tdata[LAT_LSB +: LAT_BITS]),
    .lon_i        (s_axis_tdata[LON_LSB +: LON_BITS]),
    .wr_row_i     (s_axis_tdata[ROW_LSB +: ROW_BITS]),
    .wr_col_i     (s_axis_tdata[COL_LSB +: COL_BITS]),
    .wr_height_i  (s_axis_tdata[HGT_LSB +: POST_BITS]),
    .north_edge_i (north_q),
    .west_edge_i  (west_q),
    .cpd_i        (cpd_q),
    .wr_o         (post_wr),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .look_o       (look)
  );

  tghl_post_banks u_banks (
    .clk_i     (clk_i),
    .wr_i      (post_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  tghl_lerp u_lerp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .look_i         (look),
    .post_i         (rd_data),
    .res_valid_o    (res_valid),
    .res_height_o   (res_height),
    .res_in_range_o (res_in_range)
  );

  tghl_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i ({res_in_range, res_height}),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (fifo_data)
  );

  assign m_axis_tdata = fifo_data[HEIGHT_BITS-1:0];
  assign m_axis_tuser = fifo_data[HEIGHT_BITS];

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= (RESULT_PTR_BITS + 1)'(RESULT_DEPTH))
    else $error("more results outstanding than queue slots");

  a_result_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> outstanding_q != '0)
    else $error("result offered with no query outstanding");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd == CMD_WRITE) |=>
      outstanding_q == $past(outstanding_q) - (RESULT_PTR_BITS + 1)'($past(pop)))
    else $error("write item changed the result credit");

endmodule

// ----- src/tghl_post_banks.sv -----
// Post storage in four row/column parity banks, one write and four reads per cycle.
module tghl_post_banks
  import tghl_pkg::*;
(
  input  logic                      clk_i,
  input  post_wr_t                  wr_i,
  input  logic                      rd_en_i,
  input  logic [BANK_ADDR_BITS-1:0] rd_addr_i [N_BANKS],
  output logic [POST_BITS-1:0]      rd_data_o [N_BANKS]
);

  logic [BANK_SEL_BITS-1:0]  wr_bank;
  logic [BANK_ADDR_BITS-1:0] wr_addr;

  assign wr_bank = {wr_i.row[0], wr_i.col[0]};
  assign wr_addr = {wr_i.row[ROW_BITS-1:1], wr_i.col[COL_BITS-1:1]};

  for (genvar b = 0; b < N_BANKS; b++) begin : g_bank
    logic [POST_BITS-1:0] bank_mem [BANK_DEPTH];
    logic [POST_BITS-1:0] rdata_q;

    always_ff @(posedge clk_i) begin
      if (wr_i.en && wr_bank == BANK_SEL_BITS'(b)) begin
        bank_mem[wr_addr] <= wr_i.height;
      end
      if (rd_en_i) begin
        rdata_q <= bank_mem[rd_addr_i[b]];
      end
    end

    assign rd_data_o[b] = rdata_q;
  end

endmodule

// ----- src/tghl_scale.sv -----
// Query scaling to cell positions, coverage check and bank address generation.
module tghl_scale
  import tghl_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  cmd_e                      cmd_i,
  input  logic signed [LAT_BITS-1:0] lat_i,
  input  logic signed [LON_BITS-1:0] lon_i,
  input  logic [ROW_BITS-1:0]       wr_row_i,
  input  logic [COL_BITS-1:0]       wr_col_i,
  input  logic [POST_BITS-1:0]      wr_height_i,
  input  logic signed [LAT_BITS-1:0] north_edge_i,
  input  logic signed [LON_BITS-1:0] west_edge_i,
  input  logic [CPD_BITS-1:0]       cpd_i,
  output post_wr_t                  wr_o,
  output logic                      rd_en_o,
  output logic [BANK_ADDR_BITS-1:0] rd_addr_o [N_BANKS],
  output lookup_t                   look_o
);

  localparam int PR_BITS = LAT_BITS + CPD_BITS;
  localparam int PC_BITS = LON_BITS + CPD_BITS;
  localparam logic [PR_BITS-1:0] ROW_LIMIT = PR_BITS'({LAST_ROW, {FRAC_BITS{1'b0}}});
  localparam logic [PC_BITS-1:0] COL_LIMIT = PC_BITS'({LAST_COL, {FRAC_BITS{1'b0}}});

  logic                       v1_q, v2_q;
  cmd_e                       cmd1_q, cmd2_q;
  logic signed [LAT_BITS:0]   dr1_q;
  logic signed [LON_BITS:0]   dc1_q;
  logic signed [LAT_BITS:0]   dr1_d;
  logic signed [LON_BITS:0]   dc1_d;
  logic                       ok2_q;
  logic [PR_BITS-1:0]         pr2_q;
  logic [PC_BITS-1:0]         pc2_q;
  logic [ROW_BITS-1:0]        row1_q, row2_q;
  logic [COL_BITS-1:0]        col1_q, col2_q;
  logic [POST_BITS-1:0]       hgt1_q, hgt2_q;

  logic                       covered;
  logic                       is_near;
  logic [ROW_BITS-1:0]        row;
  logic [COL_BITS-1:0]        col;
  logic [ROW_BITS:0]          row_inc;
  logic [COL_BITS:0]          col_inc;
  logic [ROW_BITS-2:0]        row_half [2];
  logic [COL_BITS-2:0]        col_half [2];
  lookup_t                    look_d, look_q;

  assign dr1_d = north_edge_i - lat_i;
  assign dc1_d = lon_i - west_edge_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      look_q <= '0;
    end else begin
      v1_q   <= in_valid_i;
      v2_q   <= v1_q;
      look_q <= look_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd1_q <= cmd_i;
    dr1_q  <= dr1_d;
    dc1_q  <= dc1_d;
    row1_q <= wr_row_i;
    col1_q <= wr_col_i;
    hgt1_q <= wr_height_i;
    cmd2_q <= cmd1_q;
    ok2_q  <= !dr1_q[LAT_BITS] && !dc1_q[LON_BITS];
    pr2_q  <= dr1_q[LAT_BITS-1:0] * cpd_i;
    pc2_q  <= dc1_q[LON_BITS-1:0] * cpd_i;
    row2_q <= row1_q;
    col2_q <= col1_q;
    hgt2_q <= hgt1_q;
  end

  always_comb begin
    covered = ok2_q && (pr2_q <= ROW_LIMIT) && (pc2_q <= COL_LIMIT);
    is_near = (cmd2_q == CMD_NEAREST);
    row     = pr2_q[FRAC_BITS +: ROW_BITS];
    col     = pc2_q[FRAC_BITS +: COL_BITS];
    row_inc = {1'b0, row} + (ROW_BITS + 1)'(1);
    col_inc = {1'b0, col} + (COL_BITS + 1)'(1);

    row_half[0] = row[0] ? row_inc[ROW_BITS-1:1] : row[ROW_BITS-1:1];
    row_half[1] = row[0] ? row[ROW_BITS-1:1] : row_inc[ROW_BITS-1:1];
    col_half[0] = col[0] ? col_inc[COL_BITS-1:1] : col[COL_BITS-1:1];
    col_half[1] = col[0] ? col[COL_BITS-1:1] : col_inc[COL_BITS-1:1];

    for (int p = 0; p < 2; p++) begin
      for (int q = 0; q < 2; q++) begin
        rd_addr_o[2*p+q] = {row_half[p], col_half[q]};
      end
    end

    look_d.valid     = v2_q && (cmd2_q == CMD_NEAREST || cmd2_q == CMD_BILINEAR);
    look_d.ok        = covered;
    look_d.frac_row  = is_near ? '0 : pr2_q[FRAC_BITS-1 -: WEIGHT_BITS];
    look_d.frac_col  = is_near ? '0 : pc2_q[FRAC_BITS-1 -: WEIGHT_BITS];
    look_d.clamp_row = is_near || (row == LAST_ROW);
    look_d.clamp_col = is_near || (col == LAST_COL);
    look_d.row_odd   = row[0];
    look_d.col_odd   = col[0];

    wr_o.en     = v2_q && (cmd2_q == CMD_WRITE);
    wr_o.row    = row2_q;
    wr_o.col    = col2_q;
    wr_o.height = hgt2_q;
  end

  assign rd_en_o = look_d.valid;
  assign look_o  = look_q;

endmodule

// ----- src/tghl_lerp.sv -----
// Bilinear blend pipeline: neighbor select, column lerps, row lerp, Q8 reduction.
module tghl_lerp
  import tghl_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lookup_t                       look_i,
  input  logic [POST_BITS-1:0]          post_i [N_BANKS],
  output logic                          res_valid_o,
  output logic signed [HEIGHT_BITS-1:0] res_height_o,
  output logic                          res_in_range_o
);

  localparam int STAGES   = 6;
  localparam int DIFF_BITS = POST_BITS + 1;
  localparam int PT_BITS  = DIFF_BITS + WEIGHT_BITS;
  localparam int TOP_BITS = PT_BITS + 1;
  localparam int VD_BITS  = TOP_BITS + 1;
  localparam int SUM_BITS = VD_BITS + WEIGHT_BITS + 1;
  localparam int RES_LSB  = 2 * WEIGHT_BITS - 8;

  logic [STAGES-1:0]             vld_q, ok_q;
  logic signed [POST_BITS-1:0]   pa, pb, pc, pd;
  logic [BANK_SEL_BITS-1:0]      idx_a, idx_b, idx_c, idx_d;
  logic signed [POST_BITS-1:0]   a4_q, c4_q, a5_q, c5_q;
  logic signed [DIFF_BITS-1:0]   dt4_q, db4_q;
  logic [WEIGHT_BITS-1:0]        fc4_q;
  logic [WEIGHT_BITS-1:0]        fr4_q, fr5_q, fr6_q, fr7_q;
  logic signed [PT_BITS-1:0]     pt5_q, pb5_q;
  logic signed [TOP_BITS-1:0]    a_ext, c_ext;
  logic signed [TOP_BITS-1:0]    top6_q, bot6_q, top7_q, top8_q;
  logic signed [VD_BITS-1:0]     vd7_q;
  logic signed [SUM_BITS-1:0]    prod8_q;
  logic signed [SUM_BITS-1:0]    top_ext, sum;
  logic signed [HEIGHT_BITS-1:0] height_q;

  always_comb begin
    idx_a = { look_i.row_odd,  look_i.col_odd};
    idx_b = { look_i.row_odd, ~look_i.col_odd};
    idx_c = {~look_i.row_odd,  look_i.col_odd};
    idx_d = {~look_i.row_odd, ~look_i.col_odd};
    pa = post_i[idx_a];
    pb = look_i.clamp_col ? pa : post_i[idx_b];
    pc = look_i.clamp_row ? pa : post_i[idx_c];
    pd = look_i.clamp_row ? pb : (look_i.clamp_col ? pc : post_i[idx_d]);

    a_ext   = {{(TOP_BITS-POST_BITS-WEIGHT_BITS){a5_q[POST_BITS-1]}}, a5_q, {WEIGHT_BITS{1'b0}}};
    c_ext   = {{(TOP_BITS-POST_BITS-WEIGHT_BITS){c5_q[POST_BITS-1]}}, c5_q, {WEIGHT_BITS{1'b0}}};
    top_ext = {{(SUM_BITS-TOP_BITS-WEIGHT_BITS){top8_q[TOP_BITS-1]}}, top8_q,
               {WEIGHT_BITS{1'b0}}};
    sum     = top_ext + prod8_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ok_q  <= '0;
    end else begin
      vld_q <= {vld_q[STAGES-2:0], look_i.valid};
      ok_q  <= {ok_q[STAGES-2:0], look_i.ok};
    end
  end

  always_ff @(posedge clk_i) begin
    a4_q   <= pa;
    c4_q   <= pc;
    dt4_q  <= pb - pa;
    db4_q  <= pd - pc;
    fc4_q  <= look_i.frac_col;
    fr4_q  <= look_i.frac_row;

    pt5_q  <= dt4_q * $signed({1'b0, fc4_q});
    pb5_q  <= db4_q * $signed({1'b0, fc4_q});
    a5_q   <= a4_q;
    c5_q   <= c4_q;
    fr5_q  <= fr4_q;

    top6_q <= a_ext + pt5_q;
    bot6_q <= c_ext + pb5_q;
    fr6_q  <= fr5_q;

    vd7_q  <= bot6_q - top6_q;
    top7_q <= top6_q;
    fr7_q  <= fr6_q;

    prod8_q <= vd7_q * $signed({1'b0, fr7_q});
    top8_q  <= top7_q;

    height_q <= ok_q[STAGES-2] ? sum[RES_LSB +: HEIGHT_BITS] : '0;
  end

  assign res_valid_o    = vld_q[STAGES-1];
  assign res_in_range_o = ok_q[STAGES-1];
  assign res_height_o   = height_q;

endmodule

// ----- src/tghl_result_fifo.sv -----
// Result queue between the lookup pipeline and the output stream.
module tghl_result_fifo
  import tghl_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [HEIGHT_BITS:0]   push_data_i,
  input  logic                   pop_i,
  output logic                   valid_o,
  output logic [HEIGHT_BITS:0]   data_o
);

  logic [HEIGHT_BITS:0]       entry_q [RESULT_DEPTH];
  logic [RESULT_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [RESULT_PTR_BITS:0]   count_q, count_d;
  logic                       pop;

  assign valid_o = (count_q != '0);
  assign pop     = pop_i && valid_o;
  assign data_o  = entry_q[rd_ptr_q];
  assign count_d = count_q + (RESULT_PTR_BITS + 1)'(push_i) - (RESULT_PTR_BITS + 1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + RESULT_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + RESULT_PTR_BITS'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != (RESULT_PTR_BITS + 1)'(RESULT_DEPTH))
    else $error("result pushed into a full queue");

endmodule
